// ----- rtl/core/drq_pkg.sv -----
// ----------------------------------------------------------------------------
// drq_pkg
// Types and constants shared by the disk request queue and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package drq_pkg;

  // input item codes
  localparam logic CMD_SUBMIT   = 1'b0;
  localparam logic CMD_COMPLETE = 1'b1;

  // configuration register indexes
  localparam logic REG_RETRY_LIMIT      = 1'b0;
  localparam logic REG_BLOCKS_PER_DRIVE = 1'b1;

  localparam logic [3:0]  RETRY_LIMIT_RST      = 4'd10;
  localparam logic [12:0] BLOCKS_PER_DRIVE_RST = 13'd4872;

  // controller command words (octal)
  localparam logic [15:0] CW_READ  = 16'o105;
  localparam logic [15:0] CW_WRITE = 16'o103;
  localparam logic [15:0] CW_RESET = 16'd1;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_RESET = 2'd2
  } kind_t;

  // one queued request, 57 bits
  typedef struct packed {
    logic [7:0]  tag;
    logic [15:0] daddr;
    logic [15:0] baddr;
    logic [15:0] wcount;
    logic        rd;
  } entry_t;

  // v / 12 as (v / 4) / 3, the divide by 3 by reciprocal, exact for 16-bit v
  function automatic logic [12:0] div12(input logic [15:0] v);
    logic [29:0] p;
    p = 30'(v[15:2]) * 30'(17'd43691);
    return p[29:17];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/disk_request_queue_with_retry_top.sv -----
// ----------------------------------------------------------------------------
// disk_request_queue_with_retry_top
// Queues disk transfer requests, starts them one at a time and retries
// a transfer the controller reports as failed.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. A submit passes
// through the bound check stage and is then rejected or queued; a queued
// submit starts a transfer at once when none is running. A transfer start
// waits for the registered read of the request queue memory, which must be
// re-read each time the queue head moves. Results come out as one-cycle
// strobes on out_valid, at most three per transaction, the final one flagged
// by out_last; the receiver cannot stall them. A completion with no transfer
// running gives no result and leaves busy low.
`default_nettype none

module disk_request_queue_with_retry_top #(
  parameter int QUEUE_DEPTH = 8
) (
  input  wire         clk,
  input  wire         rst_n,
  // input channel
  input  wire         start,
  output logic        busy,
  input  wire         in_command,
  input  wire  [7:0]  in_request_tag,
  input  wire  [3:0]  in_unit_minor,
  input  wire  [15:0] in_block_number,
  input  wire  [15:0] in_buffer_address,
  input  wire  [15:0] in_word_count,
  input  wire         in_is_read,
  input  wire         in_error_flag,
  // result channel
  output logic        out_valid,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_request_tag_res,
  output logic [15:0] out_disk_address,
  output logic [15:0] out_bus_address,
  output logic [15:0] out_count_word,
  output logic [15:0] out_command_word,
  output logic        out_failed,
  output logic        out_last,
  // configuration
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire         cfg_index,
  input  wire  [12:0] cfg_data
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_ENQ,
    S_RD,
    S_CMPL,
    S_DONE,
    S_START
  } state_t;

  state_t state_r, state_nxt;

  logic [3:0]    retry_limit_r;
  logic [12:0]   bpd_r;
  logic [PW-1:0] head_r, head_nxt;
  logic [PW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          active_r, active_nxt;
  logic [3:0]    ecount_r, ecount_nxt;

  // latched transaction
  logic [7:0]    tag_r;
  logic [3:0]    unit_r;
  logic [15:0]   blk_r;
  logic [15:0]   baddr_r;
  logic [15:0]   wcount_r;
  logic          rd_r;
  logic          err_r;
  logic          reject_r, reject_nxt;
  logic [12:0]   quot_r, quot_nxt;
  logic          fail_r, fail_nxt;

  // result registers
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_kind_r, out_kind_nxt;
  logic [7:0]    out_tag_r, out_tag_nxt;
  logic [15:0]   out_daddr_r, out_daddr_nxt;
  logic [15:0]   out_baddr_r, out_baddr_nxt;
  logic [15:0]   out_wcount_r, out_wcount_nxt;
  logic [15:0]   out_cw_r, out_cw_nxt;
  logic          out_failed_r, out_failed_nxt;
  logic          out_last_r, out_last_nxt;

  // queue memory
  logic             ram_we;
  drq_pkg::entry_t  ram_wdata;
  drq_pkg::entry_t  head_entry;
  logic [$bits(drq_pkg::entry_t)-1:0] ram_rdata;

  logic          accept;
  logic [3:0]    span;
  logic [16:0]   limit;
  logic [15:0]   quot_x12;
  logic [15:0]   rem16;
  logic [2:0]    drive;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  drq_ram #(
    .WIDTH($bits(drq_pkg::entry_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata (ram_wdata),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  assign head_entry = drq_pkg::entry_t'(ram_rdata);

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // bound check and block split
  assign span  = (unit_r > 4'd8) ? unit_r - 4'd7 : 4'd1;
  assign limit = 17'(bpd_r) * 17'(span);

  assign quot_x12 = {quot_r, 3'b000} + {1'b0, quot_r, 2'b00};
  assign rem16    = blk_r - quot_x12;
  assign drive    = unit_r[3] ? 3'd0 : unit_r[2:0];

  always_comb begin
    ram_wdata.tag    = tag_r;
    ram_wdata.daddr  = {drive, 13'd0} | {quot_r[11:0], 4'd0} | {12'd0, rem16[3:0]};
    ram_wdata.baddr  = baddr_r;
    ram_wdata.wcount = wcount_r;
    ram_wdata.rd     = rd_r;
  end

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    active_nxt     = active_r;
    ecount_nxt     = ecount_r;
    reject_nxt     = reject_r;
    quot_nxt       = quot_r;
    fail_nxt       = fail_r;
    ram_we         = 1'b0;
    out_valid_nxt  = 1'b0;
    out_kind_nxt   = out_kind_r;
    out_tag_nxt    = out_tag_r;
    out_daddr_nxt  = out_daddr_r;
    out_baddr_nxt  = out_baddr_r;
    out_wcount_nxt = out_wcount_r;
    out_cw_nxt     = out_cw_r;
    out_failed_nxt = out_failed_r;
    out_last_nxt   = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_command == drq_pkg::CMD_SUBMIT) begin
            state_nxt = S_CHECK;
          end else if (!active_r || count_r == '0) begin
            // nothing running, completion dropped
            active_nxt = 1'b0;
          end else begin
            active_nxt = 1'b0;
            state_nxt  = S_CMPL;
          end
        end
      end

      S_CHECK: begin
        reject_nxt = ({1'b0, blk_r} >= limit) || (count_r >= CW'(QUEUE_DEPTH));
        quot_nxt   = drq_pkg::div12(blk_r);
        state_nxt  = S_ENQ;
      end

      S_ENQ: begin
        if (reject_r) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = drq_pkg::KIND_DONE;
          out_tag_nxt    = tag_r;
          out_daddr_nxt  = '0;
          out_baddr_nxt  = '0;
          out_wcount_nxt = '0;
          out_cw_nxt     = '0;
          out_failed_nxt = 1'b1;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          ram_we    = 1'b1;
          tail_nxt  = ptr_inc(tail_r);
          count_nxt = count_r + 1'b1;
          state_nxt = active_r ? S_IDLE : S_RD;
        end
      end

      // head moved or was just written: wait for the memory read
      S_RD: begin
        state_nxt = S_START;
      end

      S_CMPL: begin
        if (err_r) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = drq_pkg::KIND_RESET;
          out_tag_nxt    = '0;
          out_daddr_nxt  = '0;
          out_baddr_nxt  = '0;
          out_wcount_nxt = '0;
          out_cw_nxt     = drq_pkg::CW_RESET;
          out_failed_nxt = 1'b0;
          out_last_nxt   = 1'b0;
        end
        if (err_r && (ecount_r < retry_limit_r)) begin
          ecount_nxt = ecount_r + 1'b1;
          state_nxt  = S_START;
        end else begin
          fail_nxt  = err_r;
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        out_valid_nxt  = 1'b1;
        out_kind_nxt   = drq_pkg::KIND_DONE;
        out_tag_nxt    = head_entry.tag;
        out_daddr_nxt  = '0;
        out_baddr_nxt  = '0;
        out_wcount_nxt = '0;
        out_cw_nxt     = '0;
        out_failed_nxt = fail_r;
        out_last_nxt   = (count_r == CW'(1));
        ecount_nxt     = '0;
        head_nxt       = ptr_inc(head_r);
        count_nxt      = count_r - 1'b1;
        state_nxt      = (count_r == CW'(1)) ? S_IDLE : S_RD;
      end

      S_START: begin
        out_valid_nxt  = 1'b1;
        out_kind_nxt   = drq_pkg::KIND_START;
        out_tag_nxt    = head_entry.tag;
        out_daddr_nxt  = head_entry.daddr;
        out_baddr_nxt  = head_entry.baddr;
        out_wcount_nxt = head_entry.wcount;
        out_cw_nxt     = head_entry.rd ? drq_pkg::CW_READ : drq_pkg::CW_WRITE;
        out_failed_nxt = 1'b0;
        out_last_nxt   = 1'b1;
        active_nxt     = 1'b1;
        state_nxt      = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      head_r        <= '0;
      tail_r        <= '0;
      count_r       <= '0;
      active_r      <= 1'b0;
      ecount_r      <= '0;
      out_valid_r   <= 1'b0;
      retry_limit_r <= drq_pkg::RETRY_LIMIT_RST;
      bpd_r         <= drq_pkg::BLOCKS_PER_DRIVE_RST;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      active_r    <= active_nxt;
      ecount_r    <= ecount_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          drq_pkg::REG_RETRY_LIMIT:      retry_limit_r <= cfg_data[3:0];
          drq_pkg::REG_BLOCKS_PER_DRIVE: bpd_r         <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      tag_r    <= in_request_tag;
      unit_r   <= in_unit_minor;
      blk_r    <= in_block_number;
      baddr_r  <= in_buffer_address;
      wcount_r <= in_word_count;
      rd_r     <= in_is_read;
      err_r    <= in_error_flag;
    end
    reject_r     <= reject_nxt;
    quot_r       <= quot_nxt;
    fail_r       <= fail_nxt;
    out_kind_r   <= out_kind_nxt;
    out_tag_r    <= out_tag_nxt;
    out_daddr_r  <= out_daddr_nxt;
    out_baddr_r  <= out_baddr_nxt;
    out_wcount_r <= out_wcount_nxt;
    out_cw_r     <= out_cw_nxt;
    out_failed_r <= out_failed_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_kind            = out_kind_r;
  assign out_request_tag_res = out_tag_r;
  assign out_disk_address    = out_daddr_r;
  assign out_bus_address     = out_baddr_r;
  assign out_count_word      = out_wcount_r;
  assign out_command_word    = out_cw_r;
  assign out_failed          = out_failed_r;
  assign out_last            = out_last_r;

endmodule

`default_nettype wire

// ----- rtl/core/drq_ram.sv -----
// ----------------------------------------------------------------------------
// drq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module drq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] waddr,
  input  wire  [WIDTH-1:0]         wdata,
  input  wire  [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/drq_checker.sv -----
// ----------------------------------------------------------------------------
// drq_checker
// Port-level checks on the disk request queue, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module drq_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        start,
  input wire        busy,
  input wire        in_command,
  input wire        out_valid,
  input wire [1:0]  out_kind,
  input wire [15:0] out_command_word,
  input wire        out_last
);

  // a submit always raises busy in the cycle after it is taken
  a_submit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_command == drq_pkg::CMD_SUBMIT |=> busy)
    else $error("submit transaction did not raise busy");

  // a controller reset is never the final result and carries the reset word
  a_reset_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == drq_pkg::KIND_RESET |->
      !out_last && out_command_word == drq_pkg::CW_RESET)
    else $error("bad controller reset result");

  // a transfer start always ends the transaction's results
  a_start_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == drq_pkg::KIND_START |-> out_last)
    else $error("start result not flagged last");

  // nothing follows the last result straight away
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("result right after last");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == drq_pkg::KIND_START || out_kind == drq_pkg::KIND_DONE ||
                   out_kind == drq_pkg::KIND_RESET))
    else $error("illegal result kind");

endmodule

bind disk_request_queue_with_retry_top drq_checker u_drq_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_command       (in_command),
  .out_valid        (out_valid),
  .out_kind         (out_kind),
  .out_command_word (out_command_word),
  .out_last         (out_last)
);

`default_nettype wire
